// ----- sv/ecc_pkg.sv -----
package ecc_pkg;

  // vertex set size and derived widths
  localparam int VERTICES = 8;
  localparam int VW       = (VERTICES > 1) ? $clog2(VERTICES) : 1;

  // fixed field widths
  localparam int END_W    = 3;
  localparam int IN_DW    = 8;
  localparam int OUT_DW   = 8;

  typedef logic [VERTICES-1:0] vset_t;

  // controller to datapath
  typedef struct packed {
    logic load_edge;
    logic seed;
    logic step;
    logic finish;
  } ecc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
  } ecc_sts_t;

endpackage

// ----- sv/ecc_datapath.sv -----
module ecc_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [ecc_pkg::END_W-1:0] end_a,
  input  logic [ecc_pkg::END_W-1:0] end_b,
  input  logic                   no_domino,
  input  ecc_pkg::ecc_cmd_t      cmd,
  output ecc_pkg::ecc_sts_t      sts,
  output logic                   chain_exists
);

  ecc_pkg::vset_t parity_r, parity_nxt;
  ecc_pkg::vset_t used_r, used_nxt;
  ecc_pkg::vset_t adj_r [ecc_pkg::VERTICES];
  ecc_pkg::vset_t adj_nxt [ecc_pkg::VERTICES];
  ecc_pkg::vset_t reach_r, reach_nxt;
  ecc_pkg::vset_t onehot_a, onehot_b;
  logic [ecc_pkg::VW-1:0] idx_a, idx_b;
  logic edge_ok;
  logic chain_r, chain_nxt;

  assign idx_a   = ecc_pkg::VW'(end_a);
  assign idx_b   = ecc_pkg::VW'(end_b);
  assign edge_ok = !no_domino && (int'(end_a) < ecc_pkg::VERTICES)
                   && (int'(end_b) < ecc_pkg::VERTICES);

  always_comb begin
    onehot_a = '0;
    onehot_b = '0;
    onehot_a[idx_a] = 1'b1;
    onehot_b[idx_b] = 1'b1;
  end

  // graph state update, cleared after each answer
  always_comb begin
    parity_nxt = parity_r;
    used_nxt   = used_r;
    for (int v = 0; v < ecc_pkg::VERTICES; v++) begin
      adj_nxt[v] = adj_r[v];
    end
    if (cmd.finish) begin
      parity_nxt = '0;
      used_nxt   = '0;
      for (int v = 0; v < ecc_pkg::VERTICES; v++) begin
        adj_nxt[v] = '0;
      end
    end else if (cmd.load_edge && edge_ok) begin
      parity_nxt = parity_r ^ onehot_a ^ onehot_b;
      used_nxt   = used_r | onehot_a | onehot_b;
      for (int v = 0; v < ecc_pkg::VERTICES; v++) begin
        if (onehot_a[v]) adj_nxt[v] = adj_nxt[v] | onehot_b;
        if (onehot_b[v]) adj_nxt[v] = adj_nxt[v] | onehot_a;
      end
    end
  end

  // one breadth step of the reachability walk
  always_comb begin
    reach_nxt = reach_r;
    for (int v = 0; v < ecc_pkg::VERTICES; v++) begin
      if (reach_r[v]) reach_nxt = reach_nxt | adj_r[v];
    end
  end

  assign chain_nxt = !(|parity_r) && (|used_r) && ((used_r & ~reach_r) == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= '0;
      used_r   <= '0;
      for (int v = 0; v < ecc_pkg::VERTICES; v++) begin
        adj_r[v] <= '0;
      end
    end else begin
      parity_r <= parity_nxt;
      used_r   <= used_nxt;
      for (int v = 0; v < ecc_pkg::VERTICES; v++) begin
        adj_r[v] <= adj_nxt[v];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      // lowest used vertex starts the walk
      reach_r <= used_r & (~used_r + 1'b1);
    end else if (cmd.step) begin
      reach_r <= reach_nxt;
    end
    if (cmd.finish) begin
      chain_r <= chain_nxt;
    end
  end

  assign sts.walk_done = (reach_nxt == reach_r);
  assign chain_exists  = chain_r;

endmodule

// ----- sv/ecc_ctrl.sv -----
module ecc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ecc_pkg::ecc_sts_t sts,
  output ecc_pkg::ecc_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_SEED = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_LOAD);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.load_edge = accept;
    cmd.seed      = (state_r == ST_SEED);
    cmd.step      = (state_r == ST_WALK);
    cmd.finish    = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_last) state_nxt = ST_SEED;
      end
      ST_SEED: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (sts.walk_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (cmd.finish) state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/euler_circuit_check.sv -----
// answer: registered after the seed state, the walk state and the done state that follow the item marked last,
//   later while an earlier answer is still held on the result channel
// throughput: one item per cycle within a set; in_tready stays low from the last item
//   until the answer is registered, through the seed, the walk of one step per cycle and the done state
// reset: synchronous, active low; clears the controller, the output valid and the
//   degree parity, used and adjacency bits
module euler_circuit_check (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ecc_pkg::IN_DW-1:0] in_tdata,   // [2:0] end_a, [5:3] end_b, [7:6] zero
  input  logic                      in_tuser,   // [0] no_domino
  input  logic                      in_tlast,   // last item of the set
  // result channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ecc_pkg::OUT_DW-1:0] out_tdata  // [0] chain_exists, [7:1] zero
);

  ecc_pkg::ecc_cmd_t cmd;
  ecc_pkg::ecc_sts_t sts;
  logic              chain_exists;

  // sequencing: load edges, seed the walk, walk, hand over the answer
  ecc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // graph bits, reach set and answer register
  ecc_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .end_a        (in_tdata[ecc_pkg::END_W-1:0]),
    .end_b        (in_tdata[2*ecc_pkg::END_W-1:ecc_pkg::END_W]),
    .no_domino    (in_tuser),
    .cmd          (cmd),
    .sts          (sts),
    .chain_exists (chain_exists)
  );

  // answer in the lowest bit, rest padded with zeros
  assign out_tdata = {{(ecc_pkg::OUT_DW-1){1'b0}}, chain_exists};

endmodule

// ----- sv/ecc_checker.sv -----
module ecc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       in_tlast,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [ecc_pkg::OUT_DW-1:0] out_tdata
);

  // a held answer keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("answer changed while stalled");

  // padding bits stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ecc_pkg::OUT_DW-1:1] == '0)
    else $error("answer padding not zero");

  // nothing is offered right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("answer offered after reset");

  // the walk blocks input after the last item of a set
  a_walk_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken during the walk");

endmodule

bind euler_circuit_check ecc_checker u_ecc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- bench/euler_circuit_check_tb.sv -----
class chain_scoreboard;
  bit             parity [ecc_pkg::VERTICES];
  ecc_pkg::vset_t adj [ecc_pkg::VERTICES];
  ecc_pkg::vset_t used;
  bit             expected_answers [$];
  int unsigned    errors;

  function new();
    clear_graph();
    errors = 0;
  endfunction

  function void clear_graph();
    for (int v = 0; v < ecc_pkg::VERTICES; v++) begin
      parity[v] = 1'b0;
      adj[v]    = '0;
    end
    used = '0;
  endfunction

  function bit closed_chain_now();
    ecc_pkg::vset_t reach;
    ecc_pkg::vset_t grown;
    for (int v = 0; v < ecc_pkg::VERTICES; v++) begin
      if (parity[v]) return 1'b0;
    end
    if (used == '0) return 1'b0;
    reach = used & (~used + 1'b1);
    for (int round = 0; round < ecc_pkg::VERTICES; round++) begin
      grown = reach;
      for (int v = 0; v < ecc_pkg::VERTICES; v++) begin
        if (reach[v]) grown |= adj[v];
      end
      reach = grown;
    end
    return (used & ~reach) == '0;
  endfunction

  function void note_item(bit [ecc_pkg::END_W-1:0] a, bit [ecc_pkg::END_W-1:0] b,
                          bit none, bit fin);
    if (!none && a < ecc_pkg::VERTICES && b < ecc_pkg::VERTICES) begin
      parity[a] ^= 1'b1;
      parity[b] ^= 1'b1;
      adj[a][b] = 1'b1;
      adj[b][a] = 1'b1;
      used[a]   = 1'b1;
      used[b]   = 1'b1;
    end
    if (fin) begin
      expected_answers.push_back(closed_chain_now());
      clear_graph();
    end
  endfunction

  task report(string what, int got, int want);
    $display("mismatch %0s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task check_result(bit got);
    bit want;
    if (expected_answers.size() == 0) begin
      report("answer with none outstanding", got, -1);
    end else begin
      want = expected_answers.pop_front();
      if (got !== want) report("chain_exists", got, want);
    end
  endtask
endclass

module euler_circuit_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;  // cycles with no handshake on either side
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int ITEM_TARGET = 2000;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [ecc_pkg::IN_DW-1:0]    in_tdata;   // [2:0] end_a, [5:3] end_b, [7:6] zero
  logic                         in_tuser;   // [0] no_domino
  logic                         in_tlast;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [ecc_pkg::OUT_DW-1:0]   out_tdata;  // [0] chain_exists, [7:1] zero

  chain_scoreboard sb = new();

  bit          calm;           // no idling on either side while set
  bit          hold_off;       // asks the receiver for a long hold-off
  int unsigned items_sent;
  int unsigned quiet_cycles;

  // domino set under construction
  bit [2:0] set_a [$];
  bit [2:0] set_b [$];

  euler_circuit_check uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one item from a falling edge, hold it until taken
  task automatic send_item(input bit [2:0] a, input bit [2:0] b, input bit none,
                           input bit fin);
    while (!calm && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, b, a};
    in_tuser  <= none;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(a, b, none, fin);
    if (!none || fin) items_sent++;
    @(negedge clk);
  endtask

  // closed walk of len dominoes over vertices lo..hi; len 1 gives a self loop
  task automatic add_closed_walk(input int len, input int lo, input int hi);
    bit [2:0] start;
    bit [2:0] here;
    bit [2:0] next_v;
    start = 3'($urandom_range(hi, lo));
    here  = start;
    for (int i = 1; i < len; i++) begin
      next_v = 3'($urandom_range(hi, lo));
      set_a.push_back(here);
      set_b.push_back(next_v);
      here = next_v;
    end
    set_a.push_back(here);
    set_b.push_back(start);
  endtask

  // shuffle the built set, flip ends at random, sprinkle empty items, mark the last
  task automatic send_built_set();
    int       n;
    int       j;
    bit [2:0] t;
    bit       tail;
    n    = set_a.size();
    tail = (n == 0) || ($urandom_range(7) == 0);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = set_a[i]; set_a[i] = set_a[j]; set_a[j] = t;
      t = set_b[i]; set_b[i] = set_b[j]; set_b[j] = t;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_item(3'($urandom_range(7)), 3'($urandom_range(7)), 1'b1, 1'b0);
      if ($urandom_range(1))
        send_item(set_b[i], set_a[i], 1'b0, (i == n - 1) && !tail);
      else
        send_item(set_a[i], set_b[i], 1'b0, (i == n - 1) && !tail);
    end
    if (tail) send_item(3'($urandom_range(7)), 3'($urandom_range(7)), 1'b1, 1'b1);
    set_a.delete();
    set_b.delete();
  endtask

  // one random set, mostly well-formed chains with random content
  task automatic build_random_set();
    int pick;
    int len;
    int k;
    pick = $urandom_range(99);
    len  = ($urandom_range(15) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
    if (pick < 45) begin
      add_closed_walk(len, 0, 7);
    end else if (pick < 55) begin
      // two chains that may or may not touch
      add_closed_walk(len, 0, 7);
      add_closed_walk($urandom_range(5, 1), 0, 7);
    end else if (pick < 65) begin
      // two chains on split halves, never connected
      add_closed_walk(len, 0, 3);
      add_closed_walk($urandom_range(5, 1), 4, 7);
    end else if (pick < 77) begin
      // chain with one domino missing
      add_closed_walk(len, 0, 7);
      if (set_a.size() > 1) begin
        k = $urandom_range(set_a.size() - 1);
        set_a.delete(k);
        set_b.delete(k);
      end
    end else if (pick < 89) begin
      // chain with one stray domino
      add_closed_walk(len, 0, 7);
      set_a.push_back(3'($urandom_range(7)));
      set_b.push_back(3'($urandom_range(7)));
    end else begin
      // plain noise, possibly empty
      k = $urandom_range(6);
      for (int i = 0; i < k; i++) begin
        set_a.push_back(3'($urandom_range(7)));
        set_b.push_back(3'($urandom_range(7)));
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off counted here
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      out_tready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[0]);
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL euler_circuit_check");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int set_count;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    in_tlast     = 1'b0;
    calm         = 1'b0;
    hold_off     = 1'b0;
    items_sent   = 0;
    set_count    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty set: nothing used, answer no
    send_item(3'd0, 3'd0, 1'b1, 1'b1);
    // lone self loop on the top vertex
    send_item(3'd7, 3'd7, 1'b0, 1'b1);
    // doubled domino between the extremes
    send_item(3'd0, 3'd7, 1'b0, 1'b0);
    send_item(3'd7, 3'd0, 1'b0, 1'b1);
    // single domino, odd ends
    send_item(3'd3, 3'd5, 1'b0, 1'b1);
    // triangle with an empty item inside, last mark on an empty item
    send_item(3'd1, 3'd2, 1'b0, 1'b0);
    send_item(3'd7, 3'd7, 1'b1, 1'b0);
    send_item(3'd2, 3'd4, 1'b0, 1'b0);
    send_item(3'd4, 3'd1, 1'b0, 1'b0);
    send_item(3'd6, 3'd6, 1'b1, 1'b1);
    // two separate self loops, not connected
    send_item(3'd0, 3'd0, 1'b0, 1'b0);
    send_item(3'd7, 3'd7, 1'b0, 1'b1);
    // two separate doubled dominoes
    send_item(3'd0, 3'd1, 1'b0, 1'b0);
    send_item(3'd1, 3'd0, 1'b0, 1'b0);
    send_item(3'd2, 3'd3, 1'b0, 1'b0);
    send_item(3'd3, 3'd2, 1'b0, 1'b1);
    // square with a self loop hanging on it
    send_item(3'd0, 3'd1, 1'b0, 1'b0);
    send_item(3'd1, 3'd2, 1'b0, 1'b0);
    send_item(3'd5, 3'd5, 1'b0, 1'b0);
    send_item(3'd2, 3'd5, 1'b0, 1'b0);
    send_item(3'd5, 3'd0, 1'b0, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      // block fills up against a stalled receiver
      if (set_count == 60) hold_off = 1'b1;
      // sender drains before going on
      if (set_count == 120) begin
        in_tvalid <= 1'b0;
        while (sb.expected_answers.size() != 0) @(negedge clk);
      end
      calm = (set_count >= 200) && (set_count < 260);
      build_random_set();
      send_built_set();
      set_count++;
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (sb.expected_answers.size() != 0) @(posedge clk);
    repeat (ecc_pkg::VERTICES + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS euler_circuit_check");
    end else begin
      $display("FAIL euler_circuit_check");
    end
    $finish;
  end

endmodule

// ----- euler_circuit_check.f -----
sv/ecc_pkg.sv
sv/ecc_datapath.sv
sv/ecc_ctrl.sv
sv/euler_circuit_check.sv
sv/ecc_checker.sv
bench/euler_circuit_check_tb.sv
